// ===== rtl/pfx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the postfix stack evaluator: the token and
// result beats, operation codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;

  // value returned by a pop of an empty stack
  localparam logic [DATA_W-1:0] EMPTY_POP_VALUE = 32'hFFFE_7961;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MUL  = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] number;
    logic                     last_token;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     underflow;
    logic                     overflow;
    logic                     divide_by_zero;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP_R,
    S_POP_L,
    S_EXEC,
    S_DIV,
    S_FIN_RD,
    S_FIN_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic tok_load;  // capture the incoming token
    logic push;      // push number or result onto the stack
    logic pop;       // read the top entry, drop it
    logic cap_r;     // latch popped value as right operand
    logic exec;      // run the ALU or start the divider
    logic div_take;  // latch divider quotient
    logic emit;      // load the result register, clear stack and flags
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_push;
    logic tok_is_div;
    logic tok_last;
    logic right_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/postfix_stack_evaluator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix integer expression evaluator on a hardware stack, one pre-parsed
// token per input beat, one result beat per last token.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (pfx_pkg::in_t)
//  out     | output    | out_valid_o/ out_ready_i| out_data_o (pfx_pkg::out_t)
//
//  A push token is pushed. Add, subtract, multiply: two pops through the
//  single stack memory port, execute, push. Divide: the same steps, with the
//  one-bit-per-cycle divider after execute (skipped when the divisor is zero).
//  A last token adds the final pop and result load.
//  A new token is taken while a result beat waits; only the next result load
//  stalls on out_ready_i. Reset empties the stack and clears the flags at
//  once; stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pfx_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pfx_pkg::out_t      out_data_o
);
  import pfx_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfx_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// ===== rtl/pfx_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfx_div
// Signed 32-bit divider, restoring, one quotient bit per cycle; quotient
// truncates toward zero and wraps for the most negative value over -1.
// ----------------------------------------------------------------------------
module pfx_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [pfx_pkg::DATA_W-1:0] dividend_i,
  input  wire logic signed [pfx_pkg::DATA_W-1:0] divisor_i,
  output logic                                  done_o,
  output logic signed [pfx_pkg::DATA_W-1:0]     quotient_o
);
  import pfx_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] quo_q, den_q, rem_q;
  logic [DATA_W:0]   rem_shift, rem_sub;
  logic              ge;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign abs_a = dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
  assign abs_b = divisor_i[DATA_W-1]  ? (DATA_W'(0) - divisor_i)  : divisor_i;

  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign ge        = rem_shift >= {1'b0, den_q};
  assign rem_sub   = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      quo_q <= abs_a;
      den_q <= abs_b;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

// ===== rtl/pfx_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfx_ctrl
// Token sequencer: steps each token through pop, execute, push and the
// final pop of a last token, driving the datapath by commands.
// ----------------------------------------------------------------------------
module pfx_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pfx_pkg::dp_sts_t  sts_i,
  output pfx_pkg::dp_cmd_t       cmd_o
);
  import pfx_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tok_load = 1'b1;
          state_d = sts_i.in_is_push ? S_PUSH : S_POP_R;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = sts_i.tok_last ? S_FIN_RD : S_IDLE;
      end
      S_POP_R: begin
        cmd_o.pop = 1'b1;
        state_d = S_POP_L;
      end
      S_POP_L: begin
        cmd_o.cap_r = 1'b1;
        cmd_o.pop   = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = (sts_i.tok_is_div && !sts_i.right_zero) ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = S_PUSH;
        end
      end
      S_FIN_RD: begin
        cmd_o.pop = 1'b1;
        state_d = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pfx_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfx_datapath
// Stack memory with one port, stack pointer, sticky flags, operand and
// result registers, ALU with divider, and the output register.
// ----------------------------------------------------------------------------
module pfx_datapath #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfx_pkg::in_t      in_data_i,
  output pfx_pkg::out_t          out_data_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire pfx_pkg::dp_cmd_t  cmd_i,
  output pfx_pkg::dp_sts_t       sts_o
);
  import pfx_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  in_t               tok_q;
  logic [CW-1:0]     count_q, count_m1;
  logic              empty, full;
  logic              pop_empty_q;
  logic              uf_q, ov_q, dz_q;
  logic [DATA_W-1:0] right_q, res_q, pop_val, alu_res, wdata;
  logic [AW-1:0]     addr;
  logic              mem_we, mem_re, div_start, div_done;
  logic signed [DATA_W-1:0] div_quo;
  out_t              out_q;
  logic              out_valid_q;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign count_m1 = count_q - 1'b1;
  assign pop_val  = pop_empty_q ? EMPTY_POP_VALUE : rdata_q;

  assign mem_we = cmd_i.push && !full;
  assign mem_re = cmd_i.pop && !empty;
  assign addr   = cmd_i.push ? count_q[AW-1:0] : count_m1[AW-1:0];
  assign wdata  = (op_e'(tok_q.operation) == OP_PUSH) ? tok_q.number : res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  // left operand is the second pop, still sitting on the read port
  always_comb begin
    case (op_e'(tok_q.operation))
      OP_ADD:  alu_res = pop_val + right_q;
      OP_SUB:  alu_res = pop_val - right_q;
      OP_DIV:  alu_res = '0;
      default: alu_res = pop_val * right_q;
    endcase
  end

  assign div_start = cmd_i.exec && (op_e'(tok_q.operation) == OP_DIV) && (right_q != '0);

  pfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pop_val),
    .divisor_i  (right_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) begin
      tok_q <= in_data_i;
    end
    if (cmd_i.cap_r) begin
      right_q <= pop_val;
    end
    if (cmd_i.exec) begin
      res_q <= alu_res;
    end else if (cmd_i.div_take) begin
      res_q <= div_quo;
    end
    if (cmd_i.pop) begin
      pop_empty_q <= empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      uf_q    <= 1'b0;
      ov_q    <= 1'b0;
      dz_q    <= 1'b0;
    end else if (cmd_i.emit) begin
      count_q <= '0;
      uf_q    <= 1'b0;
      ov_q    <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        if (full) ov_q <= 1'b1;
        else count_q <= count_q + 1'b1;
      end
      if (cmd_i.pop) begin
        if (empty) uf_q <= 1'b1;
        else count_q <= count_m1;
      end
      if (cmd_i.exec && op_e'(tok_q.operation) == OP_DIV && right_q == '0) begin
        dz_q <= 1'b1;
      end
    end
  end

  // result register: frees the stack while a result beat waits downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.value          <= pop_val;
      out_q.underflow      <= uf_q;
      out_q.overflow       <= ov_q;
      out_q.divide_by_zero <= dz_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.in_is_push = (op_e'(in_data_i.operation) == OP_PUSH);
  assign sts_o.tok_is_div = (op_e'(tok_q.operation) == OP_DIV);
  assign sts_o.tok_last   = tok_q.last_token;
  assign sts_o.right_zero = (right_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0) && !uf_q && !ov_q && !dz_q && out_valid_q)
    else $error("emit did not clear stack state");

  a_full_push_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && full && !cmd_i.emit) |=> ov_q && full)
    else $error("push on full stack not flagged");

  a_no_emit_over_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule
`default_nettype wire
